[hdl/osri_pkg.sv]
package osri_pkg;

  typedef enum logic [2:0] {
    OP_PUSH  = 3'd0,
    OP_POP   = 3'd1,
    OP_DUP   = 3'd2,
    OP_EXCH  = 3'd3,
    OP_INDEX = 3'd4,
    OP_ROLL  = 3'd5,
    OP_CLEAR = 3'd6,
    OP_NONE  = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNDER   = 2'd1,
    ST_OVER    = 2'd2,
    ST_ROLLCNT = 2'd3
  } status_t;

  localparam int WORD_W  = 32;
  localparam int DEPTH_W = 9;

  // One memory access request from the sequencer.
  typedef struct packed {
    logic        rd_en;
    logic        wr_en;
    logic [15:0] rd_addr;
    logic [15:0] wr_addr;
    logic [31:0] wr_data;
  } mem_req_t;

endpackage

[hdl/osri_mem.sv]
module osri_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                  clk,
  input  osri_pkg::mem_req_t    req,
  output logic [31:0]           rd_data
);
  import osri_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[AW-1:0]] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr[AW-1:0]];
    end
  end
endmodule

[hdl/osri_divu.sv]
// Unsigned restoring divider, one quotient bit per cycle; remainder only.
module osri_divu (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] rem
);
  import osri_pkg::*;

  logic [31:0] q_r;
  logic [32:0] rem_r;
  logic [31:0] den_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic [32:0] shifted;
  logic [32:0] diff;

  assign shifted = {rem_r[31:0], q_r[31]};
  assign diff    = shifted - {1'b0, den_r};
  assign rem     = rem_r[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd32;
        q_r    <= dividend;
        den_r  <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        q_r <= {q_r[30:0], 1'b0};
        if (!diff[32]) begin
          rem_r <= diff;
        end else begin
          rem_r <= shifted;
        end
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end
endmodule

[hdl/operand_stack_with_roll_index.sv]
// Operand stack of 32-bit signed words held in one synchronous memory with a
// single read/write port pair. start is taken when busy is low; exactly one
// item leaves on out_valid per accepted item and the receiver cannot stall it.
// Item paths through the states: push, clear and the unused code go from
// idle to done; pop reads the new top through RD1 and RD2 (straight to done
// when it empties the stack or underflows); dup, exch and index read their
// operands through RD1 and RD2 and check in CHK, then exch writes in EXCH_WR
// and index reads in IDX_RD and writes in IDX_WR. An underflow, overflow or
// bad roll count found in CHK ends the item there. Roll reads its two
// operands, launches a 32-step remainder divide, then rotates by three
// in-place reversals, which are skipped when j mod n is 0. The top word
// is kept in a register so pop needs one read.
// No clearing pass: entries at or above the depth are never used.
module operand_stack_with_roll_index #(
  parameter int STACK_DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [2:0]                       in_operation,
  input  logic signed [31:0]               in_push_value,
  output logic                             out_valid,
  output logic [1:0]                       out_status,
  output logic signed [31:0]               out_top_value,
  output logic [8:0]                       out_stack_depth
);
  import osri_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_RD1, S_RD2, S_CHK, S_IDX_RD, S_IDX_WR, S_EXCH_WR,
    S_DIV, S_DIV_WAIT, S_REV_INIT, S_REV_RD, S_REV_WAIT, S_REV_WR,
    S_TOP_RD, S_TOP_WAIT, S_DONE
  } state_t;

  state_t         state_r;
  logic [CW-1:0]  depth_r;
  logic [31:0]    top_r;     // cached word at depth_r-1
  logic [31:0]    a_r, b_r;  // captured words
  op_t            op_r;
  logic [1:0]     st_r;
  logic [CW-1:0]  base_r, rest_r, lo_r, hi_r;
  logic [CW-1:0]  sh_r;
  logic [1:0]     pass_r;
  logic [31:0]    n_r;
  mem_req_t       req;
  logic [31:0]    rd_data;
  logic           div_go, div_done;
  logic [31:0]    div_rem, jabs, r_norm;

  osri_mem #(.DEPTH(STACK_DEPTH), .AW(AW)) u_mem (
    .clk(clk), .req(req), .rd_data(rd_data)
  );

  // j magnitude: |j| mod n, then fix sign so the result lies in [0, n).
  assign jabs = a_r[31] ? (32'd0 - a_r) : a_r;
  assign r_norm = (a_r[31] && div_rem != 32'd0) ? (n_r - div_rem) : div_rem;

  osri_divu u_div (
    .clk(clk), .rst_n(rst_n), .go(div_go), .dividend(jabs), .divisor(n_r),
    .done(div_done), .rem(div_rem)
  );

  assign busy = (state_r != S_IDLE);
  assign div_go = (state_r == S_DIV);

  always_comb begin
    req = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req.rd_en   = 1'b1;
          req.rd_addr = 16'(depth_r - CW'(2));
          // push: write word at depth; dup too but handled later
          if (op_t'(in_operation) == OP_PUSH && depth_r < CW'(STACK_DEPTH)) begin
            req.wr_en   = 1'b1;
            req.wr_addr = 16'(depth_r);
            req.wr_data = in_push_value;
          end
          if (op_t'(in_operation) == OP_ROLL) req.rd_addr = 16'(depth_r - CW'(2));
        end
      end
      S_RD1: begin
        // second operand for roll: depth-3 read not needed (n at depth-2)
      end
      S_CHK: begin
        if (op_r == OP_DUP) begin
          if (depth_r != '0 && depth_r < CW'(STACK_DEPTH)) begin
            req.wr_en = 1'b1; req.wr_addr = 16'(depth_r); req.wr_data = top_r;
          end
        end else if (op_r == OP_INDEX) begin
          req.rd_en = 1'b1;
          req.rd_addr = 16'(depth_r - CW'(2) - CW'(top_r));
        end else if (op_r == OP_EXCH) begin
          if (depth_r >= CW'(2)) begin
            req.wr_en = 1'b1; req.wr_addr = 16'(depth_r - CW'(2)); req.wr_data = top_r;
          end
        end
      end
      S_EXCH_WR: begin
        // move the old second word into the top slot
        req.wr_en = 1'b1; req.wr_addr = 16'(depth_r - CW'(1)); req.wr_data = b_r;
      end
      S_IDX_WR: begin
        req.wr_en = 1'b1; req.wr_addr = 16'(depth_r - CW'(1)); req.wr_data = rd_data;
      end
      S_REV_RD: begin
        req.rd_en = 1'b1; req.rd_addr = 16'(lo_r);
      end
      S_REV_WAIT: begin
        req.rd_en = 1'b1; req.rd_addr = 16'(hi_r - CW'(1));
        req.wr_en = 1'b1; req.wr_addr = 16'(hi_r - CW'(1)); req.wr_data = rd_data;
      end
      S_REV_WR: begin
        req.wr_en = 1'b1; req.wr_addr = 16'(lo_r); req.wr_data = rd_data;
      end
      S_TOP_RD: begin
        req.rd_en = 1'b1; req.rd_addr = 16'(depth_r - CW'(1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      depth_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            op_r <= op_t'(in_operation);
            st_r <= ST_OK;
            unique case (op_t'(in_operation))
              OP_PUSH: begin
                if (depth_r >= CW'(STACK_DEPTH)) st_r <= ST_OVER;
                else begin
                  depth_r <= depth_r + CW'(1);
                  top_r   <= in_push_value;
                end
                state_r <= S_DONE;
              end
              OP_POP: begin
                if (depth_r == '0) begin
                  st_r <= ST_UNDER; state_r <= S_DONE;
                end else begin
                  depth_r <= depth_r - CW'(1);
                  state_r <= (depth_r == CW'(1)) ? S_DONE : S_RD1;
                end
              end
              OP_CLEAR: begin
                depth_r <= '0; state_r <= S_DONE;
              end
              OP_NONE: state_r <= S_DONE;
              default: state_r <= S_RD1;  // dup, exch, index, roll
            endcase
          end
        end
        S_RD1: begin
          // read of old depth_r-2 was issued at accept and is held in rd_data; for pop it is the new top
          state_r <= S_RD2;
        end
        S_RD2: begin
          b_r <= rd_data;
          if (op_r == OP_POP) begin
            // pop issued read at old depth-2, which is new depth-1
            top_r <= rd_data; state_r <= S_DONE;
          end else begin
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          unique case (op_r)
            OP_DUP: begin
              if (depth_r == '0) st_r <= ST_UNDER;
              else if (depth_r >= CW'(STACK_DEPTH)) st_r <= ST_OVER;
              else depth_r <= depth_r + CW'(1);
              state_r <= S_DONE;
            end
            OP_EXCH: begin
              if (depth_r < CW'(2)) begin
                st_r <= ST_UNDER; state_r <= S_DONE;
              end else state_r <= S_EXCH_WR;
            end
            OP_INDEX: begin
              if (depth_r == '0 || top_r[31] ||
                  {1'b0, top_r} >= 33'(depth_r - CW'(1))) begin
                st_r <= ST_UNDER; state_r <= S_DONE;
              end else state_r <= S_IDX_RD;
            end
            default: begin  // roll: a = j (top), b = n
              a_r <= top_r;
              n_r <= b_r;
              if (depth_r < CW'(2)) begin
                st_r <= ST_UNDER; state_r <= S_DONE;
              end else if (b_r[31] || b_r == 32'd0) begin
                st_r <= ST_ROLLCNT; state_r <= S_DONE;
              end else if ({1'b0, b_r} > 33'(depth_r - CW'(2))) begin
                st_r <= ST_UNDER; state_r <= S_DONE;
              end else begin
                rest_r  <= depth_r - CW'(2);
                depth_r <= depth_r - CW'(2);
                state_r <= S_DIV;
              end
            end
          endcase
        end
        S_EXCH_WR: begin
          // write old second word into the top slot, keep it cached
          top_r   <= b_r;
          state_r <= S_DONE;
        end
        S_IDX_RD: state_r <= S_IDX_WR;
        S_IDX_WR: begin
          top_r <= rd_data; state_r <= S_DONE;
        end
        S_DIV: state_r <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_done) begin
            base_r <= rest_r - CW'(n_r);
            sh_r   <= CW'(r_norm);
            if (r_norm == 32'd0) state_r <= S_TOP_RD;
            else begin
              pass_r <= 2'd0; state_r <= S_REV_INIT;
            end
          end
        end
        S_REV_INIT: begin
          unique case (pass_r)
            2'd0: begin lo_r <= base_r; hi_r <= rest_r; end
            2'd1: begin lo_r <= base_r; hi_r <= base_r + sh_r; end
            default: begin lo_r <= base_r + sh_r; hi_r <= rest_r; end
          endcase
          state_r <= S_REV_RD;
        end
        S_REV_RD: begin
          if (lo_r + CW'(1) < hi_r) state_r <= S_REV_WAIT;
          else if (pass_r == 2'd2) state_r <= S_TOP_RD;
          else begin
            pass_r <= pass_r + 2'd1; state_r <= S_REV_INIT;
          end
        end
        S_REV_WAIT: state_r <= S_REV_WR;
        S_REV_WR: begin
          lo_r <= lo_r + CW'(1);
          hi_r <= hi_r - CW'(1);
          state_r <= S_REV_RD;
        end
        S_TOP_RD: state_r <= S_TOP_WAIT;
        S_TOP_WAIT: begin
          top_r <= (depth_r == '0) ? 32'd0 : rd_data;
          state_r <= S_DONE;
        end
        S_DONE: begin
          out_valid       <= 1'b1;
          out_status      <= st_r;
          out_top_value   <= (depth_r == '0) ? 32'sd0 : $signed(top_r);
          out_stack_depth <= 9'(depth_r);
          state_r         <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= CW'(STACK_DEPTH))
    else $error("depth above capacity");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == S_IDLE)
    else $error("result while busy");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item not held");
endmodule
